// ===== sv/cfwt_pkg.sv =====
// shared types and constants of the ring-buffer fifo with traverse
// no dependencies
`default_nettype none

package cfwt_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataWidth    = 32;

  typedef enum logic [1:0] {
    FuncEnq  = 2'd0,
    FuncDeq  = 2'd1,
    FuncTrav = 2'd2,
    FuncClr  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    func_e                func;
    logic [DataWidth-1:0] data_in;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [DataWidth-1:0] data_out;
    logic                 last;
    logic                 is_empty;
    logic                 is_full;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/cfwt_ram.sv =====
// simple dual-port word store, one write and one registered read per cycle
// no dependencies
`default_nettype none

module cfwt_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/circular_fifo_with_traverse.sv =====
// ring-buffer fifo with traverse: pointer/count control around cfwt_ram
// depends on cfwt_pkg and cfwt_ram
// every result is registered: it appears in the cycle after its item is accepted or its read issues
// enqueue, dequeue and clear: one item per cycle, busy stays low
// traverse of N words: one read per cycle, N results back to back, busy high while the reads after the first issue
// reset clears head and count at once and sets tail to the last index; stored words are not cleared
`default_nettype none

module circular_fifo_with_traverse
  import cfwt_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      res_valid_o,
  output res_t      res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);
  localparam logic [CW-1:0] OneCnt  = CW'(1);

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, trav_idx_q, trav_idx_d;
  logic [CW-1:0] count_q, count_d, trav_left_q, trav_left_d;
  logic          trav_active_q, trav_active_d;
  logic          res_valid_q, res_valid_d;
  status_e       res_status_q, res_status_d;
  logic          res_last_q, res_last_d;
  logic          res_empty_q, res_empty_d;
  logic          res_full_q, res_full_d;
  logic          res_mem_q, res_mem_d;

  logic                 accept, is_full, is_empty;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [DataWidth-1:0] mem_rdata;

  assign accept   = start && !busy;
  assign is_full  = (count_q == FullCnt);
  assign is_empty = (count_q == '0);

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    trav_idx_d    = trav_idx_q;
    trav_left_d   = trav_left_q;
    trav_active_d = trav_active_q;
    res_valid_d   = 1'b0;
    res_status_d  = StatusOk;
    res_last_d    = 1'b1;
    res_empty_d   = is_empty;
    res_full_d    = is_full;
    res_mem_d     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = head_q;

    if (trav_active_q) begin
      mem_re      = 1'b1;
      mem_raddr   = trav_idx_q;
      res_valid_d = 1'b1;
      res_mem_d   = 1'b1;
      res_last_d  = (trav_left_q == OneCnt);
      trav_idx_d  = nxt(trav_idx_q);
      trav_left_d = trav_left_q - 1'b1;
      if (trav_left_q == OneCnt) begin
        trav_active_d = 1'b0;
      end
    end else if (accept) begin
      res_valid_d = 1'b1;
      unique case (req_i.func)
        FuncEnq: begin
          if (!is_full) begin
            mem_we      = 1'b1;
            tail_d      = nxt(tail_q);
            count_d     = count_q + 1'b1;
            res_empty_d = 1'b0;
            res_full_d  = ((count_q + 1'b1) == FullCnt);
          end else begin
            res_status_d = StatusFull;
          end
        end
        FuncDeq: begin
          if (!is_empty) begin
            mem_re      = 1'b1;
            head_d      = nxt(head_q);
            count_d     = count_q - 1'b1;
            res_mem_d   = 1'b1;
            res_empty_d = (count_q == OneCnt);
            res_full_d  = 1'b0;
          end else begin
            res_status_d = StatusEmpty;
          end
        end
        FuncTrav: begin
          if (!is_empty) begin
            mem_re        = 1'b1;
            res_mem_d     = 1'b1;
            res_last_d    = (count_q == OneCnt);
            trav_idx_d    = nxt(head_q);
            trav_left_d   = count_q - 1'b1;
            trav_active_d = (count_q != OneCnt);
          end else begin
            res_status_d = StatusEmpty;
          end
        end
        FuncClr: begin
          head_d      = '0;
          tail_d      = LastIdx;
          count_d     = '0;
          res_empty_d = 1'b1;
          res_full_d  = 1'b0;
        end
        default: begin
          res_status_d = StatusOk;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= LastIdx;
      count_q       <= '0;
      trav_idx_q    <= '0;
      trav_left_q   <= '0;
      trav_active_q <= 1'b0;
      res_valid_q   <= 1'b0;
      res_status_q  <= StatusOk;
      res_last_q    <= 1'b0;
      res_empty_q   <= 1'b1;
      res_full_q    <= 1'b0;
      res_mem_q     <= 1'b0;
    end else begin
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      trav_idx_q    <= trav_idx_d;
      trav_left_q   <= trav_left_d;
      trav_active_q <= trav_active_d;
      res_valid_q   <= res_valid_d;
      res_status_q  <= res_status_d;
      res_last_q    <= res_last_d;
      res_empty_q   <= res_empty_d;
      res_full_q    <= res_full_d;
      res_mem_q     <= res_mem_d;
    end
  end

  cfwt_ram #(
    .Depth(DEPTH),
    .Width(DataWidth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(nxt(tail_q)),
    .wdata_i(req_i.data_in),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy           = trav_active_q;
  assign res_valid_o    = res_valid_q;
  assign res_o.status   = res_status_q;
  assign res_o.data_out = res_mem_q ? mem_rdata : '0;
  assign res_o.last     = res_last_q;
  assign res_o.is_empty = res_empty_q;
  assign res_o.is_full  = res_full_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for circular_fifo_with_traverse: command words with optional random
// gaps, a ring mirror predicting every result word, checked in order as they arrive
// depends on cfwt_pkg and the rtl of circular_fifo_with_traverse
`timescale 1ns / 100ps

module tb_top;
  import cfwt_pkg::*;

  localparam int unsigned RingDepth  = DefaultDepth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 60;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  logic [DataWidth-1:0] ring_mem [RingDepth];
  int unsigned          ring_head;
  int unsigned          ring_tail;
  int unsigned          ring_count;
  res_t                 pending_results [$];
  int unsigned          error_count;
  int unsigned          cycle_count;
  bit                   gaps_on;

  circular_fifo_with_traverse u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("circular_fifo_with_traverse test failed");
      $finish;
    end
  end

  function automatic int unsigned ring_next(input int unsigned idx);
    return (idx == RingDepth - 1) ? 0 : idx + 1;
  endfunction

  function automatic void queue_result(input status_e st, input logic [DataWidth-1:0] d,
                                       input logic lst);
    res_t r;
    r.status   = st;
    r.data_out = d;
    r.last     = lst;
    r.is_empty = (ring_count == 0);
    r.is_full  = (ring_count == RingDepth);
    pending_results.push_back(r);
  endfunction

  function automatic void predict_word(input req_t w);
    int unsigned idx;
    case (w.func)
      FuncEnq: begin
        if (ring_count < RingDepth) begin
          ring_tail = ring_next(ring_tail);
          ring_mem[ring_tail] = w.data_in;
          ring_count++;
          queue_result(StatusOk, '0, 1'b1);
        end else begin
          queue_result(StatusFull, '0, 1'b1);
        end
      end
      FuncDeq: begin
        if (ring_count != 0) begin
          idx = ring_head;
          ring_head = ring_next(ring_head);
          ring_count--;
          queue_result(StatusOk, ring_mem[idx], 1'b1);
        end else begin
          queue_result(StatusEmpty, '0, 1'b1);
        end
      end
      FuncTrav: begin
        if (ring_count == 0) begin
          queue_result(StatusEmpty, '0, 1'b1);
        end else begin
          idx = ring_head;
          for (int unsigned n = 0; n < ring_count; n++) begin
            queue_result(StatusOk, ring_mem[idx], n + 1 == ring_count);
            idx = ring_next(idx);
          end
        end
      end
      default: begin
        ring_head  = 0;
        ring_tail  = RingDepth - 1;
        ring_count = 0;
        queue_result(StatusOk, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [DataWidth-1:0] exp_v,
                                      input logic [DataWidth-1:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, act_v);
    end
  endfunction

  // result words cannot be held off, so every strobe is taken at once
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t: unexpected word, expected none got %h", $time, res_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(res_o.status));
        check_field("data_out", exp_r.data_out, res_o.data_out);
        check_field("last", 32'(exp_r.last), 32'(res_o.last));
        check_field("is_empty", 32'(exp_r.is_empty), 32'(res_o.is_empty));
        check_field("is_full", 32'(exp_r.is_full), 32'(res_o.is_full));
      end
    end
  end

  task automatic send_word(input func_e f, input logic [DataWidth-1:0] d);
    req_t w;
    w.func    = f;
    w.data_in = d;
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    predict_word(w);
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        start <= 1'b0;
        req_i <= {2'($urandom_range(3)), 32'($urandom)};
        @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_word(FuncDeq, 32'hDEAD_BEEF);
    send_word(FuncTrav, 32'hFFFF_FFFF);
    send_word(FuncClr, 32'h1234_5678);
    send_word(FuncEnq, 32'hFFFF_FFFF);
    send_word(FuncTrav, 32'h0);
    send_word(FuncDeq, 32'h0);
  endtask

  task automatic test_fill_to_full();
    logic [DataWidth-1:0] d;
    for (int unsigned i = 0; i < RingDepth; i++) begin
      case (i)
        0:       d = 32'h0000_0000;
        1:       d = 32'hFFFF_FFFF;
        2:       d = 32'hAAAA_AAAA;
        3:       d = 32'h5555_5555;
        default: d = i[0] ? ~(32'h1 << (i * 2)) : (32'h1 << (i * 2 + 1));
      endcase
      send_word(FuncEnq, d);
    end
    send_word(FuncEnq, 32'hCAFE_F00D);
    send_word(FuncTrav, 32'h0);
    send_word(FuncClr, 32'h0);
  endtask

  task automatic test_random_traffic(input int unsigned n_words, input bit use_gaps);
    int unsigned burst_left;
    bit          drain_bias;
    int unsigned pick;
    func_e       f;
    logic [DataWidth-1:0] d;
    gaps_on    = use_gaps;
    burst_left = 0;
    drain_bias = 1'b0;
    for (int unsigned i = 0; i < n_words; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 8);
        drain_bias = $urandom_range(1);
      end
      burst_left--;
      pick = $urandom_range(99);
      if (drain_bias) begin
        if (pick < 25)      f = FuncEnq;
        else if (pick < 75) f = FuncDeq;
        else if (pick < 95) f = FuncTrav;
        else                f = FuncClr;
      end else begin
        if (pick < 65)      f = FuncEnq;
        else if (pick < 82) f = FuncDeq;
        else if (pick < 96) f = FuncTrav;
        else                f = FuncClr;
      end
      pick = $urandom_range(99);
      if (pick < 8)       d = '0;
      else if (pick < 16) d = '1;
      else                d = $urandom;
      send_word(f, d);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    ring_head   = 0;
    ring_tail   = RingDepth - 1;
    ring_count  = 0;
    error_count = 0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_to_full();
    wait_all_results();
    test_random_traffic(90, 1'b1);
    wait_all_results();
    test_random_traffic(40, 1'b0);
    test_random_traffic(56, 1'b1);
    wait_all_results();
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("circular_fifo_with_traverse test passed");
    end else begin
      $display("circular_fifo_with_traverse test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cfwt_pkg.sv
sv/cfwt_ram.sv
sv/circular_fifo_with_traverse.sv
sim/tb_top.sv
